/* hdl/diff_manchester_framed_encoder_macros.svh */
// Assertion macros shared by the encoder RTL.
// Every macro samples on clk and is switched off while arst_n is low.
`ifndef DIFF_MANCHESTER_FRAMED_ENCODER_MACROS_SVH
`define DIFF_MANCHESTER_FRAMED_ENCODER_MACROS_SVH

// Same-cycle implication
`define DMFE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DMFE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dmfe_pkg.sv */
// Shared types and constants for the differential Manchester framed encoder.
// No dependencies.
package dmfe_pkg;

	// Default flag length in bits
	localparam int FLAG_BITS_DEF = 8;

	// Fixed widths of the configuration port and registers
	localparam int PAT_W      = 8;
	localparam int LEN_CFG_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_PATTERN = 3'd0,
		REG_START_LENGTH  = 3'd1,
		REG_END_PATTERN   = 3'd2,
		REG_END_LENGTH    = 3'd3
	} cfg_reg_t;

	// Reset values
	localparam logic [PAT_W-1:0]     START_PATTERN_RST = 8'd238;
	localparam logic [LEN_CFG_W-1:0] START_LENGTH_RST  = 4'd8;
	localparam logic [PAT_W-1:0]     END_PATTERN_RST   = 8'd17;
	localparam logic [LEN_CFG_W-1:0] END_LENGTH_RST    = 4'd8;

	// Configuration register set
	typedef struct packed {
		logic [PAT_W-1:0]     start_pattern;
		logic [LEN_CFG_W-1:0] start_length;
		logic [PAT_W-1:0]     end_pattern;
		logic [LEN_CFG_W-1:0] end_length;
	} cfg_t;

endpackage

/* hdl/dmfe_cfg_regs.sv */
// Configuration register file of the framed encoder.
// Depends on dmfe_pkg.
module dmfe_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dmfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dmfe_pkg::CFG_DATA_W-1:0]    cfg_data,
	output dmfe_pkg::cfg_t                     cfg
);
	import dmfe_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_pattern <= START_PATTERN_RST;
			cfg_q.start_length  <= START_LENGTH_RST;
			cfg_q.end_pattern   <= END_PATTERN_RST;
			cfg_q.end_length    <= END_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_PATTERN: cfg_q.start_pattern <= cfg_data[PAT_W-1:0];
				REG_START_LENGTH:  cfg_q.start_length  <= cfg_data[LEN_CFG_W-1:0];
				REG_END_PATTERN:   cfg_q.end_pattern   <= cfg_data[PAT_W-1:0];
				REG_END_LENGTH:    cfg_q.end_length    <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/dmfe_run_build.sv */
// Input register and run builder: turns one data bit into its full run of
// line bits (start flag at frame start, two half-bits, end flag at frame end). Depends on dmfe_pkg.
module dmfe_run_build #(
	parameter int FLAG_BITS = dmfe_pkg::FLAG_BITS_DEF,
	parameter int RUN_W     = 2 * FLAG_BITS + 2,
	parameter int CNT_W     = $clog2(RUN_W + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dmfe_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              data_bit,
	input  logic              first_of_frame,
	input  logic              last_of_frame,
	output logic              load_valid,
	input  logic              load_ready,
	output logic [RUN_W-1:0]  load_bits,
	output logic [CNT_W-1:0]  load_count,
	output logic              load_frame_last
);
	import dmfe_pkg::*;

	localparam int LEN_W = $clog2(FLAG_BITS + 1);
	localparam int PW    = (FLAG_BITS > PAT_W) ? FLAG_BITS : PAT_W;

	logic                 valid_s1;
	logic                 data_s1;
	logic                 first_s1;
	logic                 last_s1;
	logic                 line_level_q;

	logic [PW-1:0]        sp_ext;
	logic [PW-1:0]        ep_ext;
	logic [FLAG_BITS-1:0] sp_flag;
	logic [FLAG_BITS-1:0] ep_flag;
	logic [FLAG_BITS-1:0] sp_tail;
	logic [FLAG_BITS-1:0] ep_tail;
	logic [LEN_W-1:0]     n_s;
	logic [LEN_W-1:0]     n_e;
	logic                 lvl_start;
	logic                 h0;
	logic                 h1;
	logic [RUN_W-1:0]     smask;
	logic [RUN_W-1:0]     emask;
	logic [CNT_W-1:0]     end_ofs;

	// Input register; refills when empty or when its item moves on
	assign in_ready   = !valid_s1 || load_ready;
	assign load_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_bit;
			first_s1 <= first_of_frame;
			last_s1  <= last_of_frame;
		end
	end

	// Patterns widened so positions past the register read as 0
	assign sp_ext  = PW'(cfg.start_pattern);
	assign ep_ext  = PW'(cfg.end_pattern);
	assign sp_flag = sp_ext[FLAG_BITS-1:0];
	assign ep_flag = ep_ext[FLAG_BITS-1:0];

	// Flag lengths, saturated at FLAG_BITS, zero when the mark is absent
	assign n_s = !first_s1 ? '0 :
		(32'(cfg.start_length) > FLAG_BITS) ? LEN_W'(FLAG_BITS) : LEN_W'(cfg.start_length);
	assign n_e = !last_s1 ? '0 :
		(32'(cfg.end_length) > FLAG_BITS) ? LEN_W'(FLAG_BITS) : LEN_W'(cfg.end_length);

	// Last bit of each flag
	assign sp_tail = sp_flag >> (n_s - LEN_W'(1));
	assign ep_tail = ep_flag >> (n_e - LEN_W'(1));

	// Level ahead of the data bit: frame start resets to 0, then the start flag
	assign lvl_start = first_s1 ? ((n_s != '0) ? sp_tail[0] : 1'b0) : line_level_q;

	// Half-bits: always toggle at the bit start, toggle mid-bit for a 0
	assign h0 = ~lvl_start;
	assign h1 = data_s1 ? h0 : ~h0;

	// Pack the run, first bit out in bit 0
	assign smask   = (RUN_W'(1) << n_s) - RUN_W'(1);
	assign emask   = (RUN_W'(1) << n_e) - RUN_W'(1);
	assign end_ofs = CNT_W'(n_s) + CNT_W'(2);

	assign load_bits = (RUN_W'(sp_flag) & smask)
		| (RUN_W'({h1, h0}) << n_s)
		| ((RUN_W'(ep_flag) & emask) << end_ofs);
	assign load_count      = CNT_W'(n_s) + CNT_W'(n_e) + CNT_W'(2);
	assign load_frame_last = last_s1;

	// Line level follows the last bit of each run as it is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_level_q <= 1'b0;
		end else if (load_valid && load_ready) begin
			line_level_q <= (n_e != '0) ? ep_tail[0] : h1;
		end
	end

endmodule

/* hdl/dmfe_serializer.sv */
// Output serializer: shifts a loaded run out one line bit per request.
// Depends on dmfe_pkg and the assertion macro header.
`include "diff_manchester_framed_encoder_macros.svh"
module dmfe_serializer #(
	parameter int FLAG_BITS = dmfe_pkg::FLAG_BITS_DEF,
	parameter int RUN_W     = 2 * FLAG_BITS + 2,
	parameter int CNT_W     = $clog2(RUN_W + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  logic [RUN_W-1:0]  load_bits,
	input  logic [CNT_W-1:0]  load_count,
	input  logic              load_frame_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              line_bit,
	output logic              last_of_run,
	output logic              end_of_frame
);
	import dmfe_pkg::*;

	logic [RUN_W-1:0] bits_q;
	logic [CNT_W-1:0] cnt_q;
	logic             frame_last_q;
	logic             take;

	// Next run loads when empty or as the final bit leaves
	assign out_valid  = (cnt_q != '0);
	assign take       = out_valid && out_ready;
	assign last_of_run = (cnt_q == CNT_W'(1));
	assign load_ready = !out_valid || (last_of_run && out_ready);

	assign line_bit     = bits_q[0];
	assign end_of_frame = last_of_run && frame_last_q;

	// Remaining-bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_valid && load_ready) begin
			cnt_q <= load_count;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Shift register and frame mark
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			bits_q       <= load_bits;
			frame_last_q <= load_frame_last;
		end else if (take) begin
			bits_q <= bits_q >> 1;
		end
	end

	`DMFE_ASSERT_NXT(a_load_count, load_valid && load_ready, cnt_q == $past(load_count), "run length not loaded")
	`DMFE_ASSERT_IMP(a_run_min, load_valid, load_count >= CNT_W'(2), "run shorter than two half-bits")
	`DMFE_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CNT_W'(RUN_W), "bit count past run width")

endmodule

/* hdl/diff_manchester_framed_encoder.sv */
// Differential Manchester framed encoder, top level.
// Path: a taken request is held in the input register; with an idle serializer its run is
//   loaded into the shift register, which offers one line bit per accepted output; a run is
//   2 bits for a plain data bit, up to 2*FLAG_BITS+2 with both flags, while the next item waits.
// Reset: arst_n clears the pipeline, line level to 0 and registers to defaults.
// Depends on dmfe_pkg, dmfe_cfg_regs, dmfe_run_build, dmfe_serializer.
module diff_manchester_framed_encoder #(
	parameter int FLAG_BITS = dmfe_pkg::FLAG_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             data_bit,
	input  logic                             first_of_frame,
	input  logic                             last_of_frame,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             line_bit,
	output logic                             last_of_run,
	output logic                             end_of_frame,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dmfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dmfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dmfe_pkg::*;

	localparam int RUN_W = 2 * FLAG_BITS + 2;
	localparam int CNT_W = $clog2(RUN_W + 1);

	cfg_t             cfg;
	logic             load_valid;
	logic             load_ready;
	logic [RUN_W-1:0] load_bits;
	logic [CNT_W-1:0] load_count;
	logic             load_frame_last;

	// Configuration registers
	dmfe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register and run builder
	dmfe_run_build #(
		.FLAG_BITS (FLAG_BITS),
		.RUN_W     (RUN_W),
		.CNT_W     (CNT_W)
	) u_build (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_bit        (data_bit),
		.first_of_frame  (first_of_frame),
		.last_of_frame   (last_of_frame),
		.load_valid      (load_valid),
		.load_ready      (load_ready),
		.load_bits       (load_bits),
		.load_count      (load_count),
		.load_frame_last (load_frame_last)
	);

	// Output serializer
	dmfe_serializer #(
		.FLAG_BITS (FLAG_BITS),
		.RUN_W     (RUN_W),
		.CNT_W     (CNT_W)
	) u_ser (
		.clk             (clk),
		.arst_n          (arst_n),
		.load_valid      (load_valid),
		.load_ready      (load_ready),
		.load_bits       (load_bits),
		.load_count      (load_count),
		.load_frame_last (load_frame_last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.line_bit        (line_bit),
		.last_of_run     (last_of_run),
		.end_of_frame    (end_of_frame)
	);

endmodule

/* dv/diff_manchester_framed_encoder_test.sv */
// Self-checking testbench for the differential Manchester framed encoder.
// Covers frame flags, data half-bits and register writes, with random stalls on both sides.
// Depends on dmfe_pkg and diff_manchester_framed_encoder.
module diff_manchester_framed_encoder_test;
	import dmfe_pkg::*;

	localparam int FLAG_BITS = FLAG_BITS_DEF;
	// First index past the defined registers; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_BASE = 3'd4;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_CHUNK = 31;

	// One line bit with its markers
	typedef struct packed {
		logic line_bit;
		logic last_of_run;
		logic end_of_frame;
	} line_sym_t;

	// Encoder predictor plus queue of line bits still due
	class line_scoreboard;
		cfg_t        regs;
		bit          level;
		int unsigned run_left;
		line_sym_t   due[$];
		int unsigned mismatches;
		int unsigned requests;
		int unsigned frames;
		int unsigned bits_seen;

		function new();
			regs.start_pattern = START_PATTERN_RST;
			regs.start_length  = START_LENGTH_RST;
			regs.end_pattern   = END_PATTERN_RST;
			regs.end_length    = END_LENGTH_RST;
			level = 1'b0;
		endfunction

		function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_START_PATTERN: regs.start_pattern = value;
				REG_START_LENGTH:  regs.start_length  = value[LEN_CFG_W-1:0];
				REG_END_PATTERN:   regs.end_pattern   = value;
				REG_END_LENGTH:    regs.end_length    = value[LEN_CFG_W-1:0];
				default: ;
			endcase
		endfunction

		// Lengths above the flag size saturate
		function int unsigned flag_len(logic [LEN_CFG_W-1:0] len);
			return (len > FLAG_BITS) ? FLAG_BITS : int'(len);
		endfunction

		// Every bit that goes out, flag or data, becomes the new line level
		function void push_bit(bit b, bit eof);
			line_sym_t sym;
			run_left--;
			sym.line_bit     = b;
			sym.last_of_run  = (run_left == 0);
			sym.end_of_frame = eof;
			due.push_back(sym);
			level = b;
		endfunction

		function void note_request(bit data, bit first, bit last);
			int unsigned n_start;
			int unsigned n_end;
			int unsigned k;
			bit h0;
			bit h1;
			requests++;
			n_start = first ? flag_len(regs.start_length) : 0;
			n_end   = last ? flag_len(regs.end_length) : 0;
			run_left = n_start + 2 + n_end;
			// Frame opening restarts from level 0 before the start flag
			if (first) begin
				frames++;
				level = 1'b0;
			end
			for (k = 0; k < n_start; k++)
				push_bit(regs.start_pattern[k], 1'b0);
			// First half always toggles; second toggles again only for a 0
			h0 = ~level;
			h1 = data ? h0 : ~h0;
			push_bit(h0, 1'b0);
			push_bit(h1, last && (n_end == 0));
			for (k = 0; k < n_end; k++)
				push_bit(regs.end_pattern[k], (k + 1) == n_end);
		endfunction

		task report(string what);
			$display("ERROR: line bit %0d: %s", bits_seen, what);
			mismatches++;
		endtask

		task check_result(bit b, bit lor, bit eof);
			line_sym_t want;
			if (due.size() == 0) begin
				report("line bit with nothing outstanding");
			end else begin
				want = due.pop_front();
				if (b != want.line_bit)
					report($sformatf("line_bit got %0b want %0b", b, want.line_bit));
				if (lor != want.last_of_run)
					report($sformatf("last_of_run got %0b want %0b", lor, want.last_of_run));
				if (eof != want.end_of_frame)
					report($sformatf("end_of_frame got %0b want %0b", eof, want.end_of_frame));
			end
			bits_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic data_bit = 1'b0;
	logic first_of_frame = 1'b0;
	logic last_of_frame = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic line_bit;
	logic last_of_run;
	logic end_of_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	line_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pressure_requests = 0;
	int pressure_served = 0;
	int hold_left = 0;
	int unsigned settings_used = 0;

	diff_manchester_framed_encoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_bit       (data_bit),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.line_bit       (line_bit),
		.last_of_run    (last_of_run),
		.end_of_frame   (end_of_frame),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// Output side: check accepted bits, then pick next ready (random or long hold-off)
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(line_bit, last_of_run, end_of_frame);
		if (pressure_requests != pressure_served) begin
			pressure_served <= pressure_requests;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request; valid is dropped only during sender gaps
	task send_item(input bit d, input bit f, input bit l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_bit <= d;
		first_of_frame <= f;
		last_of_frame <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(d, f, l);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.apply_config(idx, value);
	endtask

	// Length registers get random upper data bits, which must be dropped
	task set_flags(input logic [7:0] sp, input int sl, input logic [7:0] ep, input int el);
		logic [CFG_DATA_W-1:0] value;
		write_reg(SPARE_REG_BASE | CFG_IDX_W'($urandom_range(3)), CFG_DATA_W'($urandom));
		write_reg(REG_START_PATTERN, sp);
		value = CFG_DATA_W'($urandom);
		value[LEN_CFG_W-1:0] = LEN_CFG_W'(sl);
		write_reg(REG_START_LENGTH, value);
		write_reg(REG_END_PATTERN, ep);
		value = CFG_DATA_W'($urandom);
		value[LEN_CFG_W-1:0] = LEN_CFG_W'(el);
		write_reg(REG_END_LENGTH, value);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Wait for all outstanding bits, then keep waiting so the block is idle
	task settle();
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function int pick_len();
		case ($urandom_range(5))
			0: return 0;
			1: return FLAG_BITS;
			2: return 15;
			default: return $urandom_range(15);
		endcase
	endfunction

	// Mostly well-formed frames, some stray and broken sequences
	task random_chunk(input int n_items);
		int count;
		int len;
		int j;
		count = 0;
		while (count < n_items) begin
			case ($urandom_range(9))
				7: begin
					send_item($urandom_range(1), 1'b0, 1'b0);
					count++;
				end
				8: begin
					// frame opened but never closed
					len = $urandom_range(1, 3);
					for (j = 0; j < len; j++)
						send_item($urandom_range(1), j == 0, 1'b0);
					count += len;
				end
				9: begin
					send_item($urandom_range(1), 1'b0, 1'b1);
					count++;
				end
				default: begin
					len = $urandom_range(1, 6);
					for (j = 0; j < len; j++)
						send_item($urandom_range(1), j == 0, j == len - 1);
					count += len;
				end
			endcase
		end
	endtask

	initial begin
		int mode;
		int c;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset flags, single and multi-bit frames, unframed and broken items
		send_idle_pct = 11;
		recv_idle_pct = 62;
		send_item(1'b0, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b0);
		send_item(1'b0, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b0, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b0, 1'b1, 1'b0);
		send_item(1'b1, 1'b1, 1'b1);
		settle();
		// empty flags: data from level 0, end marker on second half-bit
		set_flags(8'hFF, 0, 8'h00, 0);
		send_item(1'b0, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b0);
		send_item(1'b1, 1'b0, 1'b1);
		settle();
		// oversized lengths saturate
		set_flags(8'h00, 15, 8'hFF, 15);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b1);
		settle();
		set_flags(8'h96, 1, 8'h69, 3);
		send_item(1'b0, 1'b1, 1'b0);
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b0, 1'b0, 1'b1);
		settle();

		// Random: three stall profiles, three flag settings each
		for (mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 62 : 0;
			recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 11 : 0;
			for (c = 0; c < 3; c++) begin
				case (mode * 3 + c)
					0: set_flags(8'($urandom), 0, 8'($urandom), 0);
					3: set_flags(8'hFF, 15, 8'h00, FLAG_BITS);
					6: set_flags(8'h00, FLAG_BITS, 8'hFF, 15);
					default: set_flags(8'($urandom), pick_len(), 8'($urandom), pick_len());
				endcase
				// long output stall while requests keep coming
				if (mode == 2 && c == 1)
					pressure_requests <= pressure_requests + 1;
				random_chunk(ITEMS_PER_CHUNK);
				settle();
			end
		end

		$display("Covered %0d requests in %0d frames, %0d line bits checked.",
			sb.requests, sb.frames, sb.bits_seen);
		$display("Used %0d flag settings, zero and oversized lengths, and a long output stall.",
			settings_used);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("ERROR: timeout with %0d line bits outstanding", sb.due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
